FILE: rtl/tagzw_pkg.sv
// Package: widths, payload structs and constants of the triangle area gradient block.
`default_nettype none
package tagzw_pkg;

  localparam int COORD_W    = 16;
  localparam int DIMS       = 4;
  localparam int EDGE_W     = 17;
  localparam int SQ_W       = 34;
  localparam int HALF_W     = 17;
  localparam int CDOT_W     = 35;
  localparam int PP_W       = 52;
  localparam int NP_W       = 53;
  localparam int PROD_W     = 68;
  localparam int ROOT_W     = 34;
  localparam int DIV_W      = 35;
  localparam int NUM_W      = 54;
  localparam int MAG_W      = 53;
  localparam int QB         = 24;
  localparam int DREM_W     = 59;
  localparam int GRAD_W     = 24;
  localparam int LANES      = 6;
  localparam int SQRT_STEPS = 34;
  localparam int SQRT_REM_W = 70;
  localparam int FRONT_STG  = 7;

  localparam int LANE_G1Z = 0;
  localparam int LANE_G2Z = 1;
  localparam int LANE_G3Z = 2;
  localparam int LANE_G1W = 3;
  localparam int LANE_G2W = 4;
  localparam int LANE_G3W = 5;

  localparam logic signed [GRAD_W-1:0] GRAD_MAX = {1'b0, {(GRAD_W-1){1'b1}}};
  localparam logic signed [GRAD_W-1:0] GRAD_MIN = {1'b1, {(GRAD_W-1){1'b0}}};

  typedef struct packed {
    logic signed [COORD_W-1:0] v1_x;
    logic signed [COORD_W-1:0] v1_y;
    logic signed [COORD_W-1:0] v1_z;
    logic signed [COORD_W-1:0] v1_w;
    logic signed [COORD_W-1:0] v2_x;
    logic signed [COORD_W-1:0] v2_y;
    logic signed [COORD_W-1:0] v2_z;
    logic signed [COORD_W-1:0] v2_w;
    logic signed [COORD_W-1:0] v3_x;
    logic signed [COORD_W-1:0] v3_y;
    logic signed [COORD_W-1:0] v3_z;
    logic signed [COORD_W-1:0] v3_w;
  } tagzw_in_t;

  typedef struct packed {
    logic signed [GRAD_W-1:0] grad1_z;
    logic signed [GRAD_W-1:0] grad2_z;
    logic signed [GRAD_W-1:0] grad3_z;
    logic signed [GRAD_W-1:0] grad1_w;
    logic signed [GRAD_W-1:0] grad2_w;
    logic signed [GRAD_W-1:0] grad3_w;
    logic                     degenerate;
  } tagzw_out_t;

  // numerators and degenerate flag riding along the root pipeline
  typedef struct packed {
    logic                         degen;
    logic [LANES-1:0][NUM_W-1:0]  num;
  } tagzw_side_t;

endpackage
`default_nettype wire

FILE: rtl/tagzw_front.sv
// Front pipeline: edges, dot products, D = |u|^2|v|^2 - (u.v)^2 and gradient numerators.
`default_nettype none
module tagzw_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_valid,
  input  tagzw_pkg::tagzw_in_t          in_data,
  output logic                          out_valid,
  output tagzw_pkg::tagzw_side_t        out_side,
  output logic [tagzw_pkg::PROD_W-1:0]  out_d
);
  import tagzw_pkg::*;

  logic signed [COORD_W-1:0] p1 [DIMS];
  logic signed [COORD_W-1:0] p2 [DIMS];
  logic signed [COORD_W-1:0] p3 [DIMS];

  logic [FRONT_STG-1:0] vld_r;

  // stage 1
  logic signed [EDGE_W-1:0] eu_r [DIMS];
  logic signed [EDGE_W-1:0] ev_r [DIMS];
  // stage 2
  logic signed [2*EDGE_W-1:0] uu_r [DIMS];
  logic signed [2*EDGE_W-1:0] vv_r [DIMS];
  logic signed [2*EDGE_W-1:0] uv_r [DIMS];
  logic signed [EDGE_W-1:0]   u2_r [2];
  logic signed [EDGE_W-1:0]   v2_r [2];
  // stage 3
  logic [SQ_W-1:0]            a3_r, b3_r;
  logic signed [CDOT_W-1:0]   c3_r;
  logic signed [EDGE_W-1:0]   u3_r [2];
  logic signed [EDGE_W-1:0]   v3_r [2];
  // stage 4
  logic [SQ_W-1:0]            a4_r, b4_r, cabs_r;
  logic signed [PP_W-1:0]     bu_r [2];
  logic signed [PP_W-1:0]     cv_r [2];
  logic signed [PP_W-1:0]     av_r [2];
  logic signed [PP_W-1:0]     cu_r [2];
  // stage 5
  logic [SQ_W-1:0]            abll_r, ablh_r, abhl_r, abhh_r;
  logic [SQ_W-1:0]            ccll_r, cclh_r, cchl_r, cchh_r;
  logic signed [NP_W-1:0]     n2_5_r [2];
  logic signed [NP_W-1:0]     n3_5_r [2];
  // stage 6
  logic [PROD_W-1:0]          ab_r, cc_r;
  logic signed [NP_W-1:0]     n2_6_r [2];
  logic signed [NP_W-1:0]     n3_6_r [2];
  // stage 7
  logic [PROD_W-1:0]          d_r;
  tagzw_side_t                side_r;

  logic signed [CDOT_W-1:0]   cneg;
  logic [PROD_W-1:0]          abmid, ccmid;
  logic signed [NUM_W-1:0]    nsum [2];
  logic                       degen_nxt;

  always_comb begin
    p1[0] = in_data.v1_x; p1[1] = in_data.v1_y; p1[2] = in_data.v1_z; p1[3] = in_data.v1_w;
    p2[0] = in_data.v2_x; p2[1] = in_data.v2_y; p2[2] = in_data.v2_z; p2[3] = in_data.v2_w;
    p3[0] = in_data.v3_x; p3[1] = in_data.v3_y; p3[2] = in_data.v3_z; p3[3] = in_data.v3_w;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[FRONT_STG-2:0], in_valid};
    end
  end

  assign cneg  = -c3_r;
  assign abmid = (PROD_W'(ablh_r) + PROD_W'(abhl_r)) << HALF_W;
  assign ccmid = (PROD_W'(cclh_r) + PROD_W'(cchl_r)) << HALF_W;
  assign degen_nxt = (ab_r <= cc_r);

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      nsum[k] = NUM_W'(n2_6_r[k]) + NUM_W'(n3_6_r[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < DIMS; k++) begin
        eu_r[k] <= EDGE_W'(p2[k]) - EDGE_W'(p1[k]);
        ev_r[k] <= EDGE_W'(p3[k]) - EDGE_W'(p1[k]);
        uu_r[k] <= eu_r[k] * eu_r[k];
        vv_r[k] <= ev_r[k] * ev_r[k];
        uv_r[k] <= eu_r[k] * ev_r[k];
      end
      for (int k = 0; k < 2; k++) begin
        u2_r[k] <= eu_r[k+2];
        v2_r[k] <= ev_r[k+2];
        u3_r[k] <= u2_r[k];
        v3_r[k] <= v2_r[k];
      end
      a3_r <= SQ_W'(uu_r[0]) + SQ_W'(uu_r[1]) + SQ_W'(uu_r[2]) + SQ_W'(uu_r[3]);
      b3_r <= SQ_W'(vv_r[0]) + SQ_W'(vv_r[1]) + SQ_W'(vv_r[2]) + SQ_W'(vv_r[3]);
      c3_r <= CDOT_W'(uv_r[0]) + CDOT_W'(uv_r[1]) + CDOT_W'(uv_r[2]) + CDOT_W'(uv_r[3]);

      a4_r   <= a3_r;
      b4_r   <= b3_r;
      cabs_r <= c3_r[CDOT_W-1] ? SQ_W'(cneg) : SQ_W'(c3_r);
      for (int k = 0; k < 2; k++) begin
        bu_r[k] <= $signed({1'b0, b3_r}) * u3_r[k];
        cv_r[k] <= c3_r * v3_r[k];
        av_r[k] <= $signed({1'b0, a3_r}) * v3_r[k];
        cu_r[k] <= c3_r * u3_r[k];
      end

      abll_r <= a4_r[HALF_W-1:0] * b4_r[HALF_W-1:0];
      ablh_r <= a4_r[HALF_W-1:0] * b4_r[SQ_W-1:HALF_W];
      abhl_r <= a4_r[SQ_W-1:HALF_W] * b4_r[HALF_W-1:0];
      abhh_r <= a4_r[SQ_W-1:HALF_W] * b4_r[SQ_W-1:HALF_W];
      ccll_r <= cabs_r[HALF_W-1:0] * cabs_r[HALF_W-1:0];
      cclh_r <= cabs_r[HALF_W-1:0] * cabs_r[SQ_W-1:HALF_W];
      cchl_r <= cabs_r[SQ_W-1:HALF_W] * cabs_r[HALF_W-1:0];
      cchh_r <= cabs_r[SQ_W-1:HALF_W] * cabs_r[SQ_W-1:HALF_W];
      for (int k = 0; k < 2; k++) begin
        n2_5_r[k] <= NP_W'(bu_r[k]) - NP_W'(cv_r[k]);
        n3_5_r[k] <= NP_W'(av_r[k]) - NP_W'(cu_r[k]);
        n2_6_r[k] <= n2_5_r[k];
        n3_6_r[k] <= n3_5_r[k];
      end

      ab_r <= {abhh_r, {SQ_W{1'b0}}} + abmid + PROD_W'(abll_r);
      cc_r <= {cchh_r, {SQ_W{1'b0}}} + ccmid + PROD_W'(ccll_r);

      d_r          <= degen_nxt ? '0 : ab_r - cc_r;
      side_r.degen <= degen_nxt;
      for (int k = 0; k < 2; k++) begin
        side_r.num[3*k]     <= -nsum[k];
        side_r.num[3*k + 1] <= NUM_W'(n2_6_r[k]);
        side_r.num[3*k + 2] <= NUM_W'(n3_6_r[k]);
      end
    end
  end

  assign out_valid = vld_r[FRONT_STG-1];
  assign out_side  = side_r;
  assign out_d     = d_r;

endmodule
`default_nettype wire

FILE: rtl/tagzw_sqrt.sv
// Pipelined integer square root of D, one result bit per stage.
`default_nettype none
module tagzw_sqrt (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_valid,
  input  tagzw_pkg::tagzw_side_t        in_side,
  input  logic [tagzw_pkg::PROD_W-1:0]  in_d,
  output logic                          out_valid,
  output tagzw_pkg::tagzw_side_t        out_side,
  output logic [tagzw_pkg::ROOT_W-1:0]  out_root
);
  import tagzw_pkg::*;

  logic                  vld_r  [SQRT_STEPS];
  logic [SQRT_REM_W-1:0] rem_r  [SQRT_STEPS];
  logic [ROOT_W-1:0]     root_r [SQRT_STEPS];
  tagzw_side_t           side_r [SQRT_STEPS];

  for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_step
    logic [SQRT_REM_W-1:0] rem_in;
    logic [SQRT_REM_W-1:0] trial;
    logic [ROOT_W-1:0]     root_in;
    tagzw_side_t           side_in;
    logic                  vld_in;
    logic                  take;

    if (i == 0) begin : g_first
      assign rem_in  = SQRT_REM_W'(in_d);
      assign root_in = '0;
      assign side_in = in_side;
      assign vld_in  = in_valid;
    end else begin : g_next
      assign rem_in  = rem_r[i-1];
      assign root_in = root_r[i-1];
      assign side_in = side_r[i-1];
      assign vld_in  = vld_r[i-1];
    end

    // trial = 2*r*2^s + 2^(2s)
    assign trial = (SQRT_REM_W'(root_in) << (SQRT_STEPS - i))
                 + (SQRT_REM_W'(1) << (2 * (SQRT_STEPS - 1 - i)));
    assign take  = (rem_in >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (en) begin
        vld_r[i] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i]  <= take ? rem_in - trial : rem_in;
        root_r[i] <= take ? (root_in | (ROOT_W'(1) << (SQRT_STEPS - 1 - i))) : root_in;
        side_r[i] <= side_in;
      end
    end
  end

  assign out_valid = vld_r[SQRT_STEPS-1];
  assign out_side  = side_r[SQRT_STEPS-1];
  assign out_root  = root_r[SQRT_STEPS-1];

endmodule
`default_nettype wire

FILE: rtl/tagzw_div.sv
// Six-lane pipelined restoring divider: numerator / (2*root), truncated, saturated.
`default_nettype none
module tagzw_div (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          en,
  input  logic                                          in_valid,
  input  tagzw_pkg::tagzw_side_t                        in_side,
  input  logic [tagzw_pkg::ROOT_W-1:0]                  in_root,
  output logic                                          out_valid,
  output logic                                          out_degen,
  output logic [tagzw_pkg::LANES-1:0][tagzw_pkg::GRAD_W-1:0] out_grad
);
  import tagzw_pkg::*;

  // sign/magnitude stage
  logic              vld0_r;
  logic              dg0_r;
  logic [DIV_W-1:0]  dv0_r;
  logic [MAG_W-1:0]  mag0_r [LANES];
  logic              neg0_r [LANES];

  // quotient steps
  logic              vld_r [QB];
  logic              dg_r  [QB];
  logic [DIV_W-1:0]  dv_r  [QB];
  logic [DREM_W-1:0] rem_r [QB][LANES];
  logic [QB-1:0]     q_r   [QB][LANES];
  logic              neg_r [QB][LANES];

  // result stage
  logic              vldo_r;
  logic              dgo_r;
  logic [GRAD_W-1:0] res_r [LANES];

  logic [NUM_W-1:0]  nneg  [LANES];

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      nneg[l] = -in_side.num[l];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld0_r <= 1'b0;
    end else if (en) begin
      vld0_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dg0_r <= in_side.degen;
      dv0_r <= {in_root, 1'b0};
      for (int l = 0; l < LANES; l++) begin
        neg0_r[l] <= in_side.num[l][NUM_W-1];
        mag0_r[l] <= in_side.num[l][NUM_W-1] ? MAG_W'(nneg[l]) : MAG_W'(in_side.num[l]);
      end
    end
  end

  for (genvar j = 0; j < QB; j++) begin : g_step
    logic [DIV_W-1:0]  dv_in;
    logic              dg_in;
    logic              vld_in;
    logic [DREM_W-1:0] trial;

    if (j == 0) begin : g_first
      assign dv_in  = dv0_r;
      assign dg_in  = dg0_r;
      assign vld_in = vld0_r;
    end else begin : g_next
      assign dv_in  = dv_r[j-1];
      assign dg_in  = dg_r[j-1];
      assign vld_in = vld_r[j-1];
    end

    assign trial = DREM_W'(dv_in) << (QB - 1 - j);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[j] <= 1'b0;
      end else if (en) begin
        vld_r[j] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_r[j] <= dv_in;
        dg_r[j] <= dg_in;
      end
    end

    for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [DREM_W-1:0] rem_in;
      logic [QB-1:0]     q_in;
      logic              neg_in;
      logic              take;

      if (j == 0) begin : g_first
        assign rem_in = DREM_W'(mag0_r[l]);
        assign q_in   = '0;
        assign neg_in = neg0_r[l];
      end else begin : g_next
        assign rem_in = rem_r[j-1][l];
        assign q_in   = q_r[j-1][l];
        assign neg_in = neg_r[j-1][l];
      end

      assign take = (rem_in >= trial);

      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[j][l] <= take ? rem_in - trial : rem_in;
          q_r[j][l]   <= take ? (q_in | (QB'(1) << (QB - 1 - j))) : q_in;
          neg_r[j][l] <= neg_in;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vldo_r <= 1'b0;
    end else if (en) begin
      vldo_r <= vld_r[QB-1];
    end
  end

  // top quotient bit set means magnitude >= 2^23: saturate
  always_ff @(posedge clk) begin
    if (en) begin
      dgo_r <= dg_r[QB-1];
      for (int l = 0; l < LANES; l++) begin
        if (dg_r[QB-1]) begin
          res_r[l] <= '0;
        end else if (q_r[QB-1][l][QB-1]) begin
          res_r[l] <= neg_r[QB-1][l] ? GRAD_MIN : GRAD_MAX;
        end else begin
          res_r[l] <= neg_r[QB-1][l] ? GRAD_W'(-q_r[QB-1][l]) : GRAD_W'(q_r[QB-1][l]);
        end
      end
    end
  end

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      out_grad[l] = res_r[l];
    end
  end

  assign out_valid = vldo_r;
  assign out_degen = dgo_r;

endmodule
`default_nettype wire

FILE: rtl/triangle_area_gradient_zw_top.sv
// Top level: triangle area gradient (z and w components) streaming pipeline.
`default_nettype none
// One triangle word is taken every cycle while nothing stalls, and its result word passes
// through 7 front stages (edges, dot products, split multiplies, D and numerators), 34
// stages of the square root (one root bit each) and 26 stages of the six-lane divider
// (sign stage, 24 quotient bits, saturation). The whole pipeline advances together; when
// out_ready is low with a word waiting, in_ready drops and nothing moves. Degenerate
// triangles (D not positive) return the degenerate flag with all gradients zero.
module triangle_area_gradient_zw_top (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  tagzw_pkg::tagzw_in_t   in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output tagzw_pkg::tagzw_out_t  out_data
);
  import tagzw_pkg::*;

  logic                         en;
  logic                         f_valid;
  tagzw_side_t                  f_side;
  logic [PROD_W-1:0]            f_d;
  logic                         s_valid;
  tagzw_side_t                  s_side;
  logic [ROOT_W-1:0]            s_root;
  logic                         d_degen;
  logic [LANES-1:0][GRAD_W-1:0] d_grad;

  assign en       = out_ready | ~out_valid;
  assign in_ready = en;

  tagzw_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .out_valid (f_valid),
    .out_side  (f_side),
    .out_d     (f_d)
  );

  tagzw_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (f_valid),
    .in_side   (f_side),
    .in_d      (f_d),
    .out_valid (s_valid),
    .out_side  (s_side),
    .out_root  (s_root)
  );

  tagzw_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s_valid),
    .in_side   (s_side),
    .in_root   (s_root),
    .out_valid (out_valid),
    .out_degen (d_degen),
    .out_grad  (d_grad)
  );

  always_comb begin
    out_data.grad1_z    = d_grad[LANE_G1Z];
    out_data.grad2_z    = d_grad[LANE_G2Z];
    out_data.grad3_z    = d_grad[LANE_G3Z];
    out_data.grad1_w    = d_grad[LANE_G1W];
    out_data.grad2_w    = d_grad[LANE_G2W];
    out_data.grad3_w    = d_grad[LANE_G3W];
    out_data.degenerate = d_degen;
  end

endmodule
`default_nettype wire

FILE: test/testbench.sv
// Testbench for the triangle area gradient block: random and directed triangles, checked in order.
`timescale 1ns / 100ps
`default_nettype none
module testbench;
  import tagzw_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  tagzw_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  tagzw_out_t out_data;

  tagzw_in_t tri_q[$];
  tagzw_out_t grad_q[$];
  int mismatches = 0;
  int words_in = 0;
  int words_out = 0;
  int degen_seen = 0;
  int sat_seen = 0;
  bit stim_done = 1'b0;
  int hold_cycles = 0;
  int hold_start = 300;
  logic in_ready_seen = 1'b0;

  triangle_area_gradient_zw_top uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [GRAD_W-1:0] sat_quot(longint num, longint dv);
    longint q;
    q = num / dv;
    if (q > 64'sd8388607) q = 64'sd8388607;
    if (q < -64'sd8388608) q = -64'sd8388608;
    return q[GRAD_W-1:0];
  endfunction

  function automatic tagzw_out_t area_grad(tagzw_in_t t);
    longint p1[4], p2[4], p3[4], u[4], v[4];
    longint a, b, c, n1, n2, n3, dv;
    logic signed [135:0] d;
    logic [71:0] r, tr;
    tagzw_out_t g;
    a = 0; b = 0; c = 0;
    p1[0] = longint'(t.v1_x); p1[1] = longint'(t.v1_y);
    p1[2] = longint'(t.v1_z); p1[3] = longint'(t.v1_w);
    p2[0] = longint'(t.v2_x); p2[1] = longint'(t.v2_y);
    p2[2] = longint'(t.v2_z); p2[3] = longint'(t.v2_w);
    p3[0] = longint'(t.v3_x); p3[1] = longint'(t.v3_y);
    p3[2] = longint'(t.v3_z); p3[3] = longint'(t.v3_w);
    for (int k = 0; k < 4; k++) begin
      u[k] = p2[k] - p1[k];
      v[k] = p3[k] - p1[k];
      a += u[k] * u[k];
      b += v[k] * v[k];
      c += u[k] * v[k];
    end
    g = '0;
    d = 136'(signed'(a)) * 136'(signed'(b)) - 136'(signed'(c)) * 136'(signed'(c));
    if (d <= 0) begin
      g.degenerate = 1'b1;
      return g;
    end
    r = '0;
    for (int s = 35; s >= 0; s--) begin
      tr = r | (72'd1 << s);
      if ($signed({64'd0, tr} * {64'd0, tr}) <= d) r = tr;
    end
    dv = 2 * longint'(r);
    n2 = b * u[2] - c * v[2];
    n3 = a * v[2] - c * u[2];
    n1 = -(n2 + n3);
    g.grad1_z = sat_quot(n1, dv);
    g.grad2_z = sat_quot(n2, dv);
    g.grad3_z = sat_quot(n3, dv);
    n2 = b * u[3] - c * v[3];
    n3 = a * v[3] - c * u[3];
    n1 = -(n2 + n3);
    g.grad1_w = sat_quot(n1, dv);
    g.grad2_w = sat_quot(n2, dv);
    g.grad3_w = sat_quot(n3, dv);
    return g;
  endfunction

  function automatic logic [15:0] rand_coord(int mode);
    case (mode)
      0: return 16'($urandom);
      1: return 16'($urandom_range(0, 255)) - 16'd128;
      2: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
      default: return 16'($urandom_range(0, 8191)) - 16'd4096;
    endcase
  endfunction

  function automatic tagzw_in_t rand_tri();
    tagzw_in_t t;
    int mode;
    int kind;
    mode = $urandom_range(0, 3);
    kind = $urandom_range(0, 9);
    t = {rand_coord(mode), rand_coord(mode), rand_coord(mode), rand_coord(mode),
         rand_coord(mode), rand_coord(mode), rand_coord(mode), rand_coord(mode),
         rand_coord(mode), rand_coord(mode), rand_coord(mode), rand_coord(mode)};
    if (kind == 0) begin
      // collinear: v3 = v1 + 2*(v2 - v1) kept small
      t.v2_x = t.v1_x >>> 2; t.v2_y = t.v1_y >>> 2;
      t.v2_z = t.v1_z >>> 2; t.v2_w = t.v1_w >>> 2;
      t.v3_x = 16'(2 * t.v2_x - t.v1_x); t.v3_y = 16'(2 * t.v2_y - t.v1_y);
      t.v3_z = 16'(2 * t.v2_z - t.v1_z); t.v3_w = 16'(2 * t.v2_w - t.v1_w);
      t.v1_x = t.v1_x >>> 2; t.v1_y = t.v1_y >>> 2;
      t.v1_z = t.v1_z >>> 2; t.v1_w = t.v1_w >>> 2;
      t.v3_x = 16'(2 * t.v2_x - t.v1_x); t.v3_y = 16'(2 * t.v2_y - t.v1_y);
      t.v3_z = 16'(2 * t.v2_z - t.v1_z); t.v3_w = 16'(2 * t.v2_w - t.v1_w);
    end else if (kind == 1) begin
      t.v3_x = t.v1_x; t.v3_y = t.v1_y; t.v3_z = t.v1_z; t.v3_w = t.v1_w;
    end
    return t;
  endfunction

  initial begin
    tagzw_in_t t;
    t = '0; tri_q.push_back(t);
    t = '1; tri_q.push_back(t);
    t = '0; t.v2_x = 16'h1000; t.v3_y = 16'h1000; tri_q.push_back(t);
    t = '0; t.v2_z = 16'h1000; t.v3_w = 16'h1000; tri_q.push_back(t);
    t = '0; t.v2_z = 16'h7fff; t.v3_w = 16'h7fff; t.v1_z = 16'h8000; t.v1_w = 16'h8000;
    tri_q.push_back(t);
    // thin triangles: two long edges one unit apart at their ends
    t = '0; t.v2_z = 16'h7fff; t.v3_z = 16'h7fff; t.v3_w = 16'h0001; tri_q.push_back(t);
    t = '0; t.v2_w = 16'h8000; t.v3_w = 16'h8000; t.v3_z = 16'h0001; tri_q.push_back(t);
    t = '0; t.v2_x = 16'h0001; t.v3_y = 16'h0001; tri_q.push_back(t);
    t = {16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff,
         16'h7fff, 16'h7fff, 16'h8000, 16'h8000};
    tri_q.push_back(t);
    t = '0; t.v2_x = 16'h7fff; t.v3_x = 16'h8000; tri_q.push_back(t);
    t = {16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555,
         16'h1234, 16'hedcb, 16'h8001, 16'h7ffe};
    tri_q.push_back(t);
    t = '0; t.v2_z = 16'h1000; t.v3_z = 16'h2000; tri_q.push_back(t);
    for (int i = 0; i < 500; i++) tri_q.push_back(rand_tri());
  end

  // hold off outputs for a long stretch once, so the pipeline fills
  always @(negedge clk) begin
    if (words_in >= hold_start && hold_cycles < 200) hold_cycles <= hold_cycles + 1;
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (hold_cycles > 0 && hold_cycles < 200) out_ready <= 1'b0;
      else if (words_out > 150 && words_out < 260) out_ready <= 1'b1;
      else out_ready <= ($urandom_range(0, 99) >= 12);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        grad_q.push_back(area_grad(in_data));
        words_in <= words_in + 1;
      end
    end
  end

  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_ready_seen)) begin
      if (tri_q.size() > 0 && ((words_in >= 180 && words_in < 400) ||
          $urandom_range(0, 99) >= 12)) begin
        in_valid <= 1'b1;
        in_data <= tri_q.pop_front();
      end else begin
        in_valid <= 1'b0;
        if (tri_q.size() == 0) stim_done <= 1'b1;
      end
    end
  end

  always @(posedge clk) in_ready_seen <= in_valid && in_ready;

  always @(posedge clk) begin
    tagzw_out_t exp_g;
    if (rst_n && out_valid && out_ready) begin
      words_out <= words_out + 1;
      if (grad_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %h", out_data);
      end else begin
        exp_g = grad_q.pop_front();
        if (exp_g.degenerate) degen_seen++;
        if (exp_g.grad1_z == GRAD_MAX || exp_g.grad1_z == GRAD_MIN) sat_seen++;
        if (exp_g !== out_data) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch word %0d: exp z %0d %0d %0d w %0d %0d %0d dg %b",
                     words_out, exp_g.grad1_z, exp_g.grad2_z, exp_g.grad3_z,
                     exp_g.grad1_w, exp_g.grad2_w, exp_g.grad3_w, exp_g.degenerate);
            $display("                  got z %0d %0d %0d w %0d %0d %0d dg %b",
                     out_data.grad1_z, out_data.grad2_z, out_data.grad3_z,
                     out_data.grad1_w, out_data.grad2_w, out_data.grad3_w,
                     out_data.degenerate);
          end
        end
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;
    wait (stim_done && !in_valid && grad_q.size() == 0);
    repeat (150) @(posedge clk);
    $display("Sent %0d triangles, checked %0d result words (%0d degenerate, %0d saturated).",
             words_in, words_out, degen_seen, sat_seen);
    if (mismatches == 0 && grad_q.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  initial begin
    #400000;
    $display("Simulation FAILED");
    $finish;
  end
endmodule
`default_nettype wire

FILE: filelist.f
rtl/tagzw_pkg.sv
rtl/tagzw_front.sv
rtl/tagzw_sqrt.sv
rtl/tagzw_div.sv
rtl/triangle_area_gradient_zw_top.sv
test/testbench.sv
